/* sv/frame_time_window_statistics_assert.svh */
// ----------------------------------------------------------------------------
// frame time window statistics assertion macros
// shared concurrent property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_WINDOW_STATISTICS_ASSERT_SVH
`define FRAME_TIME_WINDOW_STATISTICS_ASSERT_SVH

// same-cycle implication
`define FTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fts_pkg.sv */
// ----------------------------------------------------------------------------
// fts_pkg
// shared constants, types and codes of the frame time window statistics block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fts_pkg;

	localparam int WINDOW_DEPTH = 128;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam int SAMPLE_W = 24;
	localparam int LEAST_W  = 18;
	localparam int RATE_W   = 20;
	localparam int SPREAD_W = 32;
	localparam int STEADY_W = 9;
	localparam int GRADE_W  = 3;
	localparam int HELD_W   = 8;
	localparam int TARGET_W = 10;

	localparam int SUM_W = SAMPLE_W + ADDR_W;
	localparam int VN_W  = SAMPLE_W + CNT_W;
	localparam int DAB_W = VN_W + ADDR_W;
	localparam int DSQ_W = 2 * SAMPLE_W + ADDR_W;
	localparam int P_W   = CNT_W + SUM_W;

	localparam int DIV_DVD_W = 64;
	localparam int DIV_DSR_W = P_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

	localparam logic [LEAST_W-1:0]  LEAST_CAP   = 18'd256000;
	localparam logic [RATE_W-1:0]   RATE_MAX    = 20'hFFFFF;
	localparam logic [31:0]         RATE_NUM    = 32'd65536000;
	localparam logic [SPREAD_W-1:0] SPREAD_MAX  = 32'hFFFF_FFFF;
	localparam logic [STEADY_W-1:0] STEADY_ONE  = 9'd256;
	localparam logic [TARGET_W-1:0] TARGET_INIT = 10'd60;
	localparam int                  AVG_ROUND   = 5;
	localparam int                  MIN_STATS_N = 10;

	// divide by ten through a reciprocal: (x * AVG_RECIP) >> AVG_SHIFT
	localparam int                  AVG_NUM_W   = RATE_W + 4;
	localparam logic [31:0]         AVG_RECIP   = 32'hCCCC_CCCD;
	localparam int                  AVG_SHIFT   = 35;

	// register index decoded from the word address bit
	localparam logic REG_TARGET = 1'b0;

	localparam logic [GRADE_W-1:0] GRADE_A = 3'd0;
	localparam logic [GRADE_W-1:0] GRADE_B = 3'd1;
	localparam logic [GRADE_W-1:0] GRADE_C = 3'd2;
	localparam logic [GRADE_W-1:0] GRADE_D = 3'd3;
	localparam logic [GRADE_W-1:0] GRADE_F = 3'd4;

	typedef enum logic [2:0] {
		OP_MEAN,
		OP_INST,
		OP_SPREAD,
		OP_STEADY
	} div_op_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                zero;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean_time;
		logic [LEAST_W-1:0]  least_time;
		logic [SAMPLE_W-1:0] greatest_time;
		logic [RATE_W-1:0]   smoothed_rate;
		logic [SPREAD_W-1:0] spread;
		logic [STEADY_W-1:0] steadiness;
		logic                spike_seen;
		logic [GRADE_W-1:0]  grade;
		logic [HELD_W-1:0]   held_count;
	} res_t;

endpackage

/* sv/frame_time_window_statistics.sv */
// each request makes two passes over the n held samples (up to 128) on the single read
// port of the sample ring and up to four 64-step divisions on the shared divider; the
// engine takes no new request until the last result is written, while a two-entry queue
// takes requests while the engine works; results wait in a register
// reset: asynchronous active low; window empty, smoothed rate zero, target rate 60
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_window_statistics
// sliding window min, max, mean, variance, spike and rate grade monitor
// ----------------------------------------------------------------------------

module frame_time_window_statistics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [23:0] sample_time,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [23:0] mean_time,
	output logic [17:0] least_time,
	output logic [23:0] greatest_time,
	output logic [19:0] smoothed_rate,
	output logic [31:0] spread,
	output logic [8:0]  steadiness,
	output logic        spike_seen,
	output logic [2:0]  grade,
	output logic [7:0]  held_count
);
	import fts_pkg::*;

	logic [TARGET_W-1:0] target_q;
	logic                head_valid;
	item_t               head;
	logic                pop;
	res_t                res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TARGET) ? 32'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_INIT;
		end else if (psel && penable && pwrite && paddr[2] == REG_TARGET) begin
			target_q <= pwdata[TARGET_W-1:0];
		end
	end

	fts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_time  (sample_time),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	fts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (head_valid),
		.item        (head),
		.item_pop    (pop),
		.target_rate (target_q),
		.res_valid   (result_valid),
		.res         (res),
		.res_ready   (result_ready)
	);

	assign mean_time     = res.mean_time;
	assign least_time    = res.least_time;
	assign greatest_time = res.greatest_time;
	assign smoothed_rate = res.smoothed_rate;
	assign spread        = res.spread;
	assign steadiness    = res.steadiness;
	assign spike_seen    = res.spike_seen;
	assign grade         = res.grade;
	assign held_count    = res.held_count;

endmodule

/* sv/fts_div.sv */
// ----------------------------------------------------------------------------
// fts_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fts_pkg::DIV_DVD_W-1:0]  dividend,
	input  logic [fts_pkg::DIV_DSR_W-1:0]  divisor,
	output logic                           done,
	output logic [fts_pkg::DIV_DVD_W-1:0]  quotient
);
	import fts_pkg::*;

	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DSR_W:0]   shifted;
	logic [DIV_DSR_W:0]   diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[DIV_DVD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_DSR_W-1:0] : shifted[DIV_DSR_W-1:0];
				quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* sv/fts_front.sv */
// ----------------------------------------------------------------------------
// fts_front
// request intake: tags zero samples and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [fts_pkg::SAMPLE_W-1:0]  sample_time,
	output logic                          head_valid,
	output fts_pkg::item_t                head,
	input  logic                          pop
);
	import fts_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       take;

	assign sample_ready = fill_q != 2'd2;
	assign head_valid   = fill_q != 2'd0;
	assign head         = slot_q[rd_ptr_q];
	assign push         = sample_valid && sample_ready;
	assign take         = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].sample <= sample_time;
			slot_q[wr_ptr_q].zero   <= sample_time == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			case ({push, take})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* sv/fts_back.sv */
// ----------------------------------------------------------------------------
// fts_back
// statistics engine: ring memory, two passes, shared divider, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  fts_pkg::item_t                item,
	output logic                          item_pop,
	input  logic [fts_pkg::TARGET_W-1:0]  target_rate,
	output logic                          res_valid,
	output fts_pkg::res_t                 res,
	input  logic                          res_ready
);
	import fts_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_WRITE  = 11'b00000000010,
		S_PASS1  = 11'b00000000100,
		S_DIV    = 11'b00000001000,
		S_RATE   = 11'b00000010000,
		S_AVG    = 11'b00000100000,
		S_PASS2  = 11'b00001000000,
		S_STEADY = 11'b00010000000,
		S_PROD   = 11'b00100000000,
		S_GRADE  = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];

	state_t              state_q;
	div_op_t             op_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                zero_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;
	logic [RATE_W-1:0]   ravg_q;
	logic [AVG_NUM_W-1:0] avg_num_q;
	logic [CNT_W-1:0]    idx_q;
	logic                v_s1, v_s2, v_s3;
	logic [SAMPLE_W-1:0] rd_s1;
	logic [SAMPLE_W-1:0] d_s2;
	logic [VN_W-1:0]     vn_s2;
	logic [2*SAMPLE_W-1:0] dd_s3;
	logic [VN_W-1:0]     dabs_s3;
	logic                spk_s3;
	logic [SUM_W-1:0]    sum_q;
	logic [LEAST_W-1:0]  lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [RATE_W-1:0]   inst_q;
	logic [DSQ_W-1:0]    devsq_q;
	logic [DAB_W-1:0]    dabs_q;
	logic [CNT_W-1:0]    spikes_q;
	logic [SPREAD_W-1:0] spread_q;
	logic [STEADY_W-1:0] steady_q;
	logic [P_W-1:0]      p_q;
	logic [GRADE_W-1:0]  grade_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                 div_start_q;
	logic [DIV_DVD_W-1:0] div_dvd_q;
	logic [DIV_DSR_W-1:0] div_dsr_q;
	logic                 div_done;
	logic [DIV_DVD_W-1:0] div_quo;

	logic                 in_pass;
	logic                 issue;
	logic                 pass_done;
	logic [31:0]          r_scaled;
	logic [31:0]          t_scaled;
	logic [GRADE_W-1:0]   grade_c;
	logic                 spike_c;
	logic [AVG_NUM_W+31:0] avg_prod;

	fts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dsr_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_pass   = state_q == S_PASS1 || state_q == S_PASS2;
	assign issue     = in_pass && idx_q < count_q;
	assign pass_done = in_pass && idx_q == count_q && !v_s1 && !v_s2 && !v_s3;
	assign item_pop  = state_q == S_IDLE && item_valid;

	// smoothed rate divided by ten with a reciprocal multiply
	assign avg_prod = (AVG_NUM_W+32)'(avg_num_q) * (AVG_NUM_W+32)'(AVG_RECIP);

	// grade thresholds: rate*100 against target*256*percent
	assign r_scaled = 32'(ravg_q) * 32'd100;
	assign t_scaled = 32'(target_rate) << 8;
	always_comb begin
		if (r_scaled >= t_scaled * 32'd95)      grade_c = GRADE_A;
		else if (r_scaled >= t_scaled * 32'd85) grade_c = GRADE_B;
		else if (r_scaled >= t_scaled * 32'd70) grade_c = GRADE_C;
		else if (r_scaled >= t_scaled * 32'd50) grade_c = GRADE_D;
		else                                    grade_c = GRADE_F;
	end

	assign spike_c = count_q >= CNT_W'(MIN_STATS_N)
		&& (32'(spikes_q) * 32'd20) > 32'(count_q);

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) ring[slot_q] <= sample_q;
		rd_s1 <= ring[idx_q[ADDR_W-1:0]];
	end

	// deviation pipeline, one entry per cycle
	always_ff @(posedge clk) begin
		d_s2    <= (rd_s1 >= mean_q) ? rd_s1 - mean_q : mean_q - rd_s1;
		vn_s2   <= VN_W'(rd_s1) * VN_W'(count_q);
		dd_s3   <= d_s2 * d_s2;
		dabs_s3 <= (vn_s2 >= VN_W'(sum_q)) ? vn_s2 - VN_W'(sum_q) : VN_W'(sum_q) - vn_s2;
		spk_s3  <= vn_s2 > VN_W'({sum_q, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_MEAN;
			sample_q    <= '0;
			zero_q      <= 1'b0;
			slot_q      <= '0;
			count_q     <= '0;
			ravg_q      <= '0;
			avg_num_q   <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			sum_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mean_q      <= '0;
			inst_q      <= '0;
			devsq_q     <= '0;
			dabs_q      <= '0;
			spikes_q    <= '0;
			spread_q    <= '0;
			steady_q    <= '0;
			p_q         <= '0;
			grade_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			div_start_q <= 1'b0;
			div_dvd_q   <= '0;
			div_dsr_q   <= '0;
		end else begin
			// start pulse lasts one cycle
			if (div_start_q) div_start_q <= 1'b0;
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			if (issue) idx_q <= idx_q + 1'b1;
			if (state_q == S_PASS1 && v_s1) begin
				sum_q <= sum_q + SUM_W'(rd_s1);
				if (SAMPLE_W'(lo_q) > rd_s1) lo_q <= rd_s1[LEAST_W-1:0];
				if (rd_s1 > hi_q) hi_q <= rd_s1;
			end
			if (state_q == S_PASS2 && v_s3) begin
				devsq_q <= devsq_q + DSQ_W'(dd_s3);
				dabs_q  <= dabs_q + DAB_W'(dabs_s3);
				if (spk_s3) spikes_q <= spikes_q + 1'b1;
			end
			if (res_valid_q && res_ready && state_q != S_DONE) res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						sample_q <= item.sample;
						zero_q   <= item.zero;
						state_q  <= S_WRITE;
					end
				end
				S_WRITE: begin
					slot_q <= (slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					if (count_q < CNT_W'(WINDOW_DEPTH)) count_q <= count_q + 1'b1;
					idx_q   <= '0;
					sum_q   <= '0;
					lo_q    <= LEAST_CAP;
					hi_q    <= '0;
					state_q <= S_PASS1;
				end
				S_PASS1: begin
					if (pass_done) begin
						op_q        <= OP_MEAN;
						div_dvd_q   <= DIV_DVD_W'(sum_q) + DIV_DVD_W'(count_q >> 1);
						div_dsr_q   <= DIV_DSR_W'(count_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						case (op_q)
							OP_MEAN: begin
								mean_q <= div_quo[SAMPLE_W-1:0];
								if (sum_q == '0) begin
									// all held samples zero: smoothed rate stays
									idx_q    <= '0;
									devsq_q  <= '0;
									dabs_q   <= '0;
									spikes_q <= '0;
									state_q  <= S_PASS2;
								end else if (zero_q) begin
									inst_q  <= RATE_MAX;
									state_q <= S_RATE;
								end else begin
									op_q        <= OP_INST;
									div_dvd_q   <= DIV_DVD_W'(RATE_NUM);
									div_dsr_q   <= DIV_DSR_W'(sample_q);
									div_start_q <= 1'b1;
								end
							end
							OP_INST: begin
								inst_q  <= (div_quo > DIV_DVD_W'(RATE_MAX)) ? RATE_MAX
									: div_quo[RATE_W-1:0];
								state_q <= S_RATE;
							end
							OP_SPREAD: begin
								spread_q <= (div_quo > DIV_DVD_W'(SPREAD_MAX)) ? SPREAD_MAX
									: div_quo[SPREAD_W-1:0];
								state_q  <= S_STEADY;
							end
							OP_STEADY: begin
								steady_q <= (div_quo >= DIV_DVD_W'(STEADY_ONE)) ? '0
									: STEADY_ONE - div_quo[STEADY_W-1:0];
								state_q  <= S_GRADE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RATE: begin
					avg_num_q <= (AVG_NUM_W'(ravg_q) << 3) + AVG_NUM_W'(ravg_q)
						+ AVG_NUM_W'(inst_q) + AVG_NUM_W'(AVG_ROUND);
					state_q   <= S_AVG;
				end
				S_AVG: begin
					ravg_q   <= avg_prod[AVG_SHIFT +: RATE_W];
					idx_q    <= '0;
					devsq_q  <= '0;
					dabs_q   <= '0;
					spikes_q <= '0;
					state_q  <= S_PASS2;
				end
				S_PASS2: begin
					if (pass_done) begin
						if (count_q >= CNT_W'(2)) begin
							op_q        <= OP_SPREAD;
							div_dvd_q   <= DIV_DVD_W'(devsq_q >> 8);
							div_dsr_q   <= DIV_DSR_W'(count_q - 1'b1);
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							spread_q <= '0;
							state_q  <= S_STEADY;
						end
					end
				end
				S_STEADY: begin
					p_q <= P_W'(count_q) * P_W'(sum_q);
					if (count_q >= CNT_W'(MIN_STATS_N) && sum_q != '0) begin
						state_q <= S_PROD;
					end else begin
						steady_q <= STEADY_ONE;
						state_q  <= S_GRADE;
					end
				end
				S_PROD: begin
					op_q        <= OP_STEADY;
					div_dvd_q   <= (DIV_DVD_W'(dabs_q) << 8) + DIV_DVD_W'(p_q >> 1);
					div_dsr_q   <= DIV_DSR_W'(p_q);
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_GRADE: begin
					grade_q <= grade_c;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_q.mean_time     <= mean_q;
						res_q.least_time    <= lo_q;
						res_q.greatest_time <= hi_q;
						res_q.smoothed_rate <= ravg_q;
						res_q.spread        <= spread_q;
						res_q.steadiness    <= steady_q;
						res_q.spike_seen    <= spike_c;
						res_q.grade         <= grade_q;
						res_q.held_count    <= HELD_W'(count_q);
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* sv/fts_chk.sv */
// ----------------------------------------------------------------------------
// fts_chk
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_time_window_statistics_assert.svh"

module fts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [23:0] mean_time,
	input logic [17:0] least_time,
	input logic [23:0] greatest_time,
	input logic [31:0] spread,
	input logic [8:0]  steadiness,
	input logic        spike_seen,
	input logic [2:0]  grade,
	input logic [7:0]  held_count
);
	import fts_pkg::*;

	`FTS_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(mean_time) && $stable(held_count), "result changed while stalled")
	`FTS_ASSERT_NOW(a_order, result_valid, least_time <= LEAST_CAP && 24'(least_time) <= greatest_time && mean_time <= greatest_time, "min mean max out of order")
	`FTS_ASSERT_NOW(a_count, result_valid, held_count != 8'd0 && 32'(held_count) <= 32'(WINDOW_DEPTH), "held count out of range")
	`FTS_ASSERT_NOW(a_small, result_valid && held_count < 8'd10, !spike_seen && steadiness == STEADY_ONE && (held_count > 8'd1 || spread == 32'd0), "short window stats wrong")
	`FTS_ASSERT_NOW(a_grade, result_valid, grade <= GRADE_F && steadiness <= STEADY_ONE, "grade or steadiness out of range")

endmodule

bind frame_time_window_statistics fts_chk u_chk (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_window_statistics testbench
// drives frame-time requests with random gaps and result stalls, rewrites the
// target rate between phases and checks every statistic against a local
// model of the window, the smoothed rate and the grade
// ----------------------------------------------------------------------------

module testbench;
	import fts_pkg::*;

	localparam int       RANDOM_ITEMS = 1500;
	localparam int       QUIET_ITEMS  = 200;
	localparam longint   CYCLE_LIMIT  = 8000000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid;
	logic        sample_ready;
	logic [23:0] sample_time;
	logic        result_valid;
	logic        result_ready;
	logic [23:0] mean_time;
	logic [17:0] least_time;
	logic [23:0] greatest_time;
	logic [19:0] smoothed_rate;
	logic [31:0] spread;
	logic [8:0]  steadiness;
	logic        spike_seen;
	logic [2:0]  grade;
	logic [7:0]  held_count;

	// window model
	logic [SAMPLE_W-1:0] win_ring [WINDOW_DEPTH];
	int unsigned         win_slot;
	int unsigned         win_count;
	logic [RATE_W-1:0]   win_rate;
	logic [TARGET_W-1:0] win_target;

	res_t   stats_pending [$];
	int     errors;
	bit     gaps_on;
	longint cycles;

	frame_time_window_statistics u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("** frame_time_window_statistics: FAILED **");
			$finish;
		end
	end

	function automatic logic [GRADE_W-1:0] grade_for(logic [RATE_W-1:0] r,
			logic [TARGET_W-1:0] t);
		longint unsigned rr, tt;
		rr = longint'(r) * 100;
		tt = longint'(t) * 256;
		if (rr >= tt * 95) return GRADE_A;
		if (rr >= tt * 85) return GRADE_B;
		if (rr >= tt * 70) return GRADE_C;
		if (rr >= tt * 50) return GRADE_D;
		return GRADE_F;
	endfunction

	function automatic res_t window_stats(logic [SAMPLE_W-1:0] s);
		res_t            r;
		longint unsigned sum, devsq, dabs, vn, d, p, q, sp, inst;
		int unsigned     n, lo, hi, mean, spikes;
		win_ring[win_slot] = s;
		win_slot = (win_slot + 1) % WINDOW_DEPTH;
		if (win_count < WINDOW_DEPTH) win_count++;
		n = win_count;
		sum = 0;
		lo = 256000;
		hi = 0;
		for (int i = 0; i < n; i++) begin
			sum += win_ring[i];
			if (win_ring[i] < lo) lo = win_ring[i];
			if (win_ring[i] > hi) hi = win_ring[i];
		end
		mean = 32'((sum + n / 2) / n);
		// all-zero window leaves the smoothed rate alone
		if (sum > 0) begin
			inst = (s == 0) ? 1048575 : 65536000 / s;
			if (inst > 1048575) inst = 1048575;
			win_rate = RATE_W'((longint'(win_rate) * 9 + inst + 5) / 10);
		end
		devsq = 0;
		dabs = 0;
		spikes = 0;
		for (int i = 0; i < n; i++) begin
			d = (win_ring[i] >= mean) ? win_ring[i] - mean : mean - win_ring[i];
			vn = longint'(win_ring[i]) * n;
			devsq += d * d;
			dabs += (vn >= sum) ? vn - sum : sum - vn;
			if (vn > 2 * sum) spikes++;
		end
		sp = 0;
		if (n >= 2) begin
			sp = devsq / (256 * longint'(n - 1));
			if (sp > 64'hFFFF_FFFF) sp = 64'hFFFF_FFFF;
		end
		r.steadiness = 9'd256;
		if (n >= 10 && sum > 0) begin
			p = longint'(n) * sum;
			q = (dabs * 256 + p / 2) / p;
			r.steadiness = (q >= 256) ? 9'd0 : 9'(256 - q);
		end
		r.mean_time     = mean[23:0];
		r.least_time    = lo[17:0];
		r.greatest_time = hi[23:0];
		r.smoothed_rate = win_rate;
		r.spread        = sp[31:0];
		r.spike_seen    = (n >= 10) && (spikes * 20 > n);
		r.grade         = grade_for(win_rate, win_target);
		r.held_count    = n[7:0];
		return r;
	endfunction

	task automatic field_check(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name,
				exp_v, act_v);
			errors++;
		end
	endtask

	// result side: stall bursts and checking
	int stall_left;
	always @(posedge clk) begin
		res_t e;
		if (result_valid && result_ready) begin
			if (stats_pending.size() == 0) begin
				$display("%0t unexpected result: expected none, actual mean %0d",
					$time, mean_time);
				errors++;
			end else begin
				e = stats_pending.pop_front();
				field_check("mean_time", e.mean_time, mean_time);
				field_check("least_time", e.least_time, least_time);
				field_check("greatest_time", e.greatest_time, greatest_time);
				field_check("smoothed_rate", e.smoothed_rate, smoothed_rate);
				field_check("spread", e.spread, spread);
				field_check("steadiness", e.steadiness, steadiness);
				field_check("spike_seen", e.spike_seen, spike_seen);
				field_check("grade", e.grade, grade);
				field_check("held_count", e.held_count, held_count);
			end
		end
		if (!gaps_on || !arst_n) begin
			result_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_time  <= s;
		do @(posedge clk); while (!sample_ready);
		stats_pending.insert(stats_pending.size(), window_stats(s));
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (stats_pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_target(logic [31:0] value);
		drain();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= 3'(REG_TARGET) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		win_target = value[TARGET_W-1:0];
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] base;
		base = 24'($urandom_range(2000, 9000));
		case ($urandom_range(0, 11))
			0: return 24'($urandom);
			1: return '0;
			2: return 24'hFFFFFF;
			3: return 24'($urandom_range(0, 300));
			4: return 24'($urandom_range(255990, 256010));
			5: return base * 24'($urandom_range(3, 20));
			default: return base;
		endcase
	endfunction

	task automatic test_directed;
		// zero first keeps the window all zero and the rate untouched
		send_sample('0);
		send_sample('0);
		send_sample(24'd1);
		send_sample(24'hFFFFFF);
		send_sample(24'd255999);
		send_sample(24'd256000);
		send_sample(24'd256001);
		send_sample(24'd62);
		send_sample(24'd63);
		for (int i = 0; i < 12; i++) send_sample(24'd4267);
		// two long frames after a steady run
		send_sample(24'd40000);
		send_sample(24'd40000);
		send_sample('0);
	endtask

	task automatic test_target_sweep;
		logic [31:0] targets [6] = '{32'd1, 32'd1000, 32'd0, 32'd1023, 32'd30, 32'd60};
		foreach (targets[k]) begin
			write_target(targets[k]);
			for (int i = 0; i < 20; i++) send_sample(pick_sample());
		end
	endtask

	task automatic test_random;
		gaps_on = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) write_target(32'd144);
			if (i == RANDOM_ITEMS - QUIET_ITEMS) gaps_on = 1'b0;
			send_sample(pick_sample());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		sample_valid = 1'b0;
		sample_time  = '0;
		result_ready = 1'b1;
		errors       = 0;
		gaps_on      = 1'b0;
		cycles       = 0;
		stall_left   = 0;
		win_slot     = 0;
		win_count    = 0;
		win_rate     = '0;
		win_target   = TARGET_INIT;
		foreach (win_ring[i]) win_ring[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_target_sweep();
		test_random();
		drain();
		repeat (600) @(posedge clk);
		if (errors == 0 && stats_pending.size() == 0) begin
			$display("** frame_time_window_statistics: PASSED **");
		end else begin
			$display("** frame_time_window_statistics: FAILED **");
		end
		$finish;
	end

endmodule
